FILE: rtl/core/sync_header_frame_deframer_assert.svh
// Assertion macros shared by the frame deframer modules.
`ifndef SYNC_HEADER_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_HEADER_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SHFD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHFD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/shfd_pkg.sv
// Types and constants for the sync-header frame deframer.
`timescale 1ns / 1ps
package shfd_pkg;

    localparam int PAYLOAD_BUFFER_BYTES = 64;
    localparam int LEN_LIMIT_INT = (PAYLOAD_BUFFER_BYTES - 1 > 63) ? 63
                                                                   : PAYLOAD_BUFFER_BYTES - 1;
    localparam logic [7:0] LEN_LIMIT = 8'(LEN_LIMIT_INT);

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [7:0] SYNC_A   = 8'h55;
    localparam logic [7:0] SYNC_B   = 8'hAA;
    localparam logic [7:0] SYNC_SUM = 8'hFF;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    typedef struct packed {
        logic       valid;
        logic [7:0] ftype;
        logic [5:0] flen;
    } t_frame_start;

endpackage

FILE: rtl/core/shfd_store.sv
// Payload store: 64 x 8 synchronous RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module shfd_store
    import shfd_pkg::*;
(
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/shfd_parser.sv
// Header/length/payload/checksum parser; writes payload words into the store.
`timescale 1ns / 1ps
module shfd_parser
    import shfd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_acc,
    input  logic [7:0]   i_byte,
    output t_wr_req      o_wr,
    output t_frame_start o_start
);

    typedef enum logic [5:0] {
        PH_HEAD1   = 6'b000001,
        PH_HEAD2   = 6'b000010,
        PH_TYPE    = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CHECK   = 6'b100000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_type,  n_type;
    logic [5:0] r_len,   n_len;
    logic [5:0] r_cnt,   n_cnt;
    logic [7:0] r_sum,   n_sum;
    logic [5:0] cnt_inc;

    assign cnt_inc = r_cnt + 6'd1;

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        o_wr    = '{en: 1'b0, addr: r_cnt[ADDR_W-1:0], data: i_byte};
        o_start = '{valid: 1'b0, ftype: r_type, flen: r_len};
        if (i_acc) begin
            unique case (r_phase)
                PH_HEAD2: begin
                    if (i_byte == SYNC_B) begin
                        n_phase = PH_TYPE;
                    end else if (i_byte == SYNC_A) begin
                        n_phase = PH_HEAD2;
                    end else begin
                        n_phase = PH_HEAD1;
                    end
                end
                PH_TYPE: begin
                    n_type  = i_byte;
                    n_sum   = SYNC_SUM + i_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (i_byte > LEN_LIMIT) begin
                        n_phase = PH_HEAD1;
                    end else begin
                        n_len   = i_byte[5:0];
                        n_sum   = r_sum + i_byte;
                        n_cnt   = 6'd0;
                        n_phase = (i_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_wr.en = 1'b1;
                    n_sum   = r_sum + i_byte;
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_start.valid = (r_sum == i_byte);
                    n_phase       = PH_HEAD1;
                end
                default: begin
                    n_phase = (i_byte == SYNC_A) ? PH_HEAD2 : PH_HEAD1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD1;
            r_type  <= 8'd0;
            r_len   <= 6'd0;
            r_cnt   <= 6'd0;
            r_sum   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
        end
    end

`include "sync_header_frame_deframer_assert.svh"

    `SHFD_ASSERT_NOW(a_wr_in_frame, o_wr.en, (r_phase == PH_PAYLOAD) && (r_cnt < r_len), "payload write outside frame")
    `SHFD_ASSERT_NOW(a_start_on_check, o_start.valid, r_phase == PH_CHECK, "frame start outside checksum phase")

endmodule

FILE: rtl/core/shfd_emit.sv
// Result sequencer: reads the stored payload back and holds each word for the sink.
`timescale 1ns / 1ps
module shfd_emit
    import shfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_frame_start      i_start,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_frame_type,
    output logic [5:0]        o_frame_len,
    output logic [7:0]        o_payload_byte,
    output logic              o_empty_frame,
    output logic              o_last_byte
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_idx,   n_idx;
    logic [7:0] r_type,  n_type;
    logic [5:0] r_len,   n_len;
    logic [7:0] r_byte,  n_byte;
    logic       r_empty, n_empty;
    logic       r_last,  n_last;
    logic       out_acc;
    logic [6:0] idx_inc;

    assign out_acc = (r_state == ST_HOLD) && i_ready;
    assign idx_inc = {1'b0, r_idx} + 7'd1;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_type    = r_type;
        n_len     = r_len;
        n_byte    = r_byte;
        n_empty   = r_empty;
        n_last    = r_last;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx[ADDR_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_start.valid) begin
                    n_type = i_start.ftype;
                    n_len  = i_start.flen;
                    n_idx  = 6'd0;
                    if (i_start.flen == 6'd0) begin
                        n_byte  = 8'd0;
                        n_empty = 1'b1;
                        n_last  = 1'b1;
                        n_state = ST_HOLD;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = '0;
                        n_empty   = 1'b0;
                        n_state   = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                n_byte  = i_rd_data;
                n_last  = (idx_inc == {1'b0, r_len});
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_ready) begin
                    if (r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx     = idx_inc[5:0];
                        o_rd_en   = 1'b1;
                        o_rd_addr = idx_inc[ADDR_W-1:0];
                        n_state   = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_type  <= n_type;
        r_len   <= n_len;
        r_byte  <= n_byte;
        r_empty <= n_empty;
        r_last  <= n_last;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_HOLD);
    assign o_frame_type   = r_type;
    assign o_frame_len    = r_len;
    assign o_payload_byte = r_byte;
    assign o_empty_frame  = r_empty;
    assign o_last_byte    = r_last;

`include "sync_header_frame_deframer_assert.svh"

    `SHFD_ASSERT_NOW(a_start_when_idle, i_start.valid, r_state == ST_IDLE, "frame start while emitting")
    `SHFD_ASSERT_NOW(a_load_in_range, r_state == ST_LOAD, r_idx < r_len, "read beyond frame length")
    `SHFD_ASSERT_NEXT(a_last_ends_run, out_acc && r_last, r_state == ST_IDLE, "run continues after last word")

endmodule

FILE: rtl/core/sync_header_frame_deframer.sv
// Top level of the sync-header frame deframer: parser, payload store, result sequencer.
//
//  channel | direction | handshake                  | word
//  rx      | in        | i_rx_valid / o_rx_ready    | i_rx_byte
//  res     | out       | o_res_valid / i_res_ready  | frame_type, frame_len, payload_byte,
//          |           |                            | empty_frame, last_byte
//
// Every header, length and payload byte is taken while rx is not held off.
// After a good checksum, rx is held off while the run is emitted: each payload word is
// read from the store into the output register; an empty-frame marker skips the read.
// A stalled sink holds the output register; rx opens again after the last word leaves.
// Synchronous active-low reset returns the parser to hunting; the store is not cleared.
`timescale 1ns / 1ps
module sync_header_frame_deframer
    import shfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_frame_type,
    output logic [5:0] o_frame_len,
    output logic [7:0] o_payload_byte,
    output logic       o_empty_frame,
    output logic       o_last_byte
);

    t_wr_req           wr;
    t_frame_start      start;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              busy;
    logic              rx_acc;

    assign o_rx_ready = !busy;
    assign rx_acc     = i_rx_valid && !busy;

    shfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (rx_acc),
        .i_byte  (i_rx_byte),
        .o_wr    (wr),
        .o_start (start)
    );

    shfd_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    shfd_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_busy         (busy),
        .o_valid        (o_res_valid),
        .i_ready        (i_res_ready),
        .o_frame_type   (o_frame_type),
        .o_frame_len    (o_frame_len),
        .o_payload_byte (o_payload_byte),
        .o_empty_frame  (o_empty_frame),
        .o_last_byte    (o_last_byte)
    );

endmodule
